// ===== rtl/skf_pkg.sv =====
`timescale 1ns / 1ps

package skf_pkg;

  // Fixed-point format and field widths
  localparam int FRAC_BITS   = 16;
  localparam int SAMPLE_BITS = 8;
  localparam int OFFSET_W    = 8;
  localparam int NOISE_W     = 24;
  localparam int EST_W       = 26;
  localparam int VAR_W       = 32;

  // Derived datapath widths
  localparam int GAIN_W   = FRAC_BITS + 1;
  localparam int DIFF_W   = ((SAMPLE_BITS > OFFSET_W) ? SAMPLE_BITS : OFFSET_W) + 1;
  localparam int MEAS_W   = DIFF_W + FRAC_BITS;
  localparam int ERR_W    = ((MEAS_W > EST_W) ? MEAS_W : EST_W) + 1;
  localparam int DEN_W    = VAR_W + 1;
  localparam int REM_W    = DEN_W;
  localparam int MUL_A_W  = GAIN_W + 1;
  localparam int MUL_B_W  = (ERR_W > VAR_W + 1) ? ERR_W : VAR_W + 1;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int STEP_W   = PROD_W - FRAC_BITS;
  localparam int SUM_W    = ((STEP_W > EST_W) ? STEP_W : EST_W) + 1;
  localparam int CNT_W    = $clog2(GAIN_W);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = NOISE_W;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_OFFSET     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 2'd2;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 8'd128;
  localparam logic [NOISE_W-1:0]  Q_RESET      = 24'd655;
  localparam logic [NOISE_W-1:0]  R_RESET      = 24'd32768;

  localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  localparam logic signed [SUM_W-1:0] EST_MAX =
    $signed({{(SUM_W-EST_W+1){1'b0}}, {(EST_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] EST_MIN =
    $signed({{(SUM_W-EST_W+1){1'b1}}, {(EST_W-1){1'b0}}});

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL_EST,
    ST_MUL_VAR,
    ST_UPDATE
  } skf_state_e;

  typedef struct packed {
    logic             start;
    logic [VAR_W-1:0] pp;
    logic [DEN_W-1:0] den;
  } skf_div_req_t;

  typedef struct packed {
    logic              done;
    logic [GAIN_W-1:0] quot;
  } skf_div_rsp_t;

endpackage

// ===== rtl/skf_if.sv =====
`timescale 1ns / 1ps

interface skf_in_if import skf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface skf_out_if import skf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [EST_W-1:0] estimate;
  logic [VAR_W-1:0]        variance;

  modport source (output valid, output estimate, output variance, input ready);
  modport sink   (input valid, input estimate, input variance, output ready);
endinterface

interface skf_cfg_if import skf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/skf_div.sv =====
`timescale 1ns / 1ps

// Restoring divider: gain = floor(pp * 2^FRAC_BITS / den), one quotient bit a cycle.
module skf_div import skf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  skf_div_req_t req_i,
  output skf_div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [GAIN_W-1:0] low_q, low_d;
  logic [GAIN_W-1:0] quot_q, quot_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [REM_W:0]    trial;
  logic [REM_W:0]    trial_sub;
  logic              fits;

  assign trial     = {rem_q, low_q[GAIN_W-1]};
  assign fits      = (trial >= {1'b0, den_q});
  assign trial_sub = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    quot_d = quot_q;
    den_d  = den_q;
    if (req_i.start) begin
      // High quotient bits are zero since pp <= den: start partway in.
      rem_d  = REM_W'(req_i.pp >> 1);
      low_d  = {req_i.pp[0], {FRAC_BITS{1'b0}}};
      den_d  = req_i.den;
      quot_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
      low_d  = {low_q[GAIN_W-2:0], 1'b0};
      quot_d = {quot_q[GAIN_W-2:0], fits};
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(GAIN_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    low_q  <= low_d;
    quot_q <= quot_d;
    den_q  <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// ===== rtl/skf_mul.sv =====
`timescale 1ns / 1ps

// Shared signed multiplier with registered product.
module skf_mul import skf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [PROD_W-1:0]  prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/scalar_kalman_filter.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Handshake      Payload
// -------  ---  -------------  --------------------------------------------
// cfg_i    in   valid / ready  index (2b), data (24b); ready always high
// in_i     in   valid / ready  sample (8b unsigned)
// out_o    out  valid / ready  estimate (26b signed Q.16), variance (32b Q.16)
//
// Each sample passes through the prepare, divide, two multiply and update
// steps; no new sample is taken until its result is loaded into the output
// register. The gain comes from the bit-serial divider in 17 quotient
// steps; a zero denominator skips the divider. The output register lets the
// next sample start while a result waits; a stalled result holds the
// update step. Reset loads the default noise and offset and clears state.

module scalar_kalman_filter import skf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  skf_cfg_if.sink   cfg_i,
  skf_in_if.sink    in_i,
  skf_out_if.source out_o
);

  skf_state_e state_q, state_d;

  // Configuration registers
  logic [OFFSET_W-1:0] offset_q;
  logic [NOISE_W-1:0]  q_noise_q;
  logic [NOISE_W-1:0]  r_noise_q;

  // Filter state
  logic signed [EST_W-1:0] last_est_q;
  logic [VAR_W-1:0]        last_var_q;

  // Per-item working registers
  logic signed [DIFF_W-1:0] diff_q;
  logic [VAR_W-1:0]         pp_q;
  logic [GAIN_W-1:0]        gain_q;
  logic signed [EST_W-1:0]  est_new_q;

  // Output register
  logic                    out_valid_q;
  logic signed [EST_W-1:0] est_out_q;
  logic [VAR_W-1:0]        var_out_q;

  logic                     in_xfer;
  logic                     out_load;
  logic [VAR_W:0]           pp_sum;
  logic [VAR_W-1:0]         pp_sat;
  logic signed [DIFF_W-1:0] diff_c;
  logic [DEN_W-1:0]         den_c;
  logic signed [MEAS_W-1:0] meas_c;
  logic signed [ERR_W-1:0]  err_c;
  logic signed [STEP_W-1:0] step_c;
  logic signed [SUM_W-1:0]  sum_c;
  logic signed [EST_W-1:0]  est_sat_c;
  logic [VAR_W-1:0]         var_new_c;

  skf_div_req_t              div_req;
  skf_div_rsp_t              div_rsp;
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_prod;

  assign in_xfer   = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // Predicted variance, saturating
  assign pp_sum = {1'b0, last_var_q} + (VAR_W + 1)'(q_noise_q);
  assign pp_sat = pp_sum[VAR_W] ? {VAR_W{1'b1}} : pp_sum[VAR_W-1:0];
  assign diff_c = $signed(DIFF_W'(in_i.sample)) - $signed(DIFF_W'(offset_q));
  assign den_c  = {1'b0, pp_q} + DEN_W'(r_noise_q);

  // Innovation: measurement scaled to fixed point minus last estimate
  assign meas_c = $signed({diff_q, {FRAC_BITS{1'b0}}});
  assign err_c  = ERR_W'(meas_c) - ERR_W'(last_est_q);

  // Drop the fraction bits of the signed product: floor toward minus infinity
  assign step_c = mul_prod[PROD_W-1:FRAC_BITS];
  assign sum_c  = SUM_W'(last_est_q) + SUM_W'(step_c);
  always_comb begin
    if (sum_c > EST_MAX) begin
      est_sat_c = EST_MAX[EST_W-1:0];
    end else if (sum_c < EST_MIN) begin
      est_sat_c = EST_MIN[EST_W-1:0];
    end else begin
      est_sat_c = sum_c[EST_W-1:0];
    end
  end

  // (1 - K) * Pp is never negative and fits 32 bits after the shift
  assign var_new_c = mul_prod[FRAC_BITS +: VAR_W];

  skf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  skf_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_prod)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        // Zero denominator forces the gain to zero: skip the divider
        state_d = (den_c == '0) ? ST_MUL_EST : ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_MUL_EST;
        end
      end
      ST_MUL_EST: state_d = ST_MUL_VAR;
      ST_MUL_VAR: state_d = ST_UPDATE;
      ST_UPDATE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_i.ready    = 1'b0;
    div_req.start = 1'b0;
    div_req.pp    = pp_q;
    div_req.den   = den_c;
    mul_en        = 1'b0;
    mul_a         = $signed({1'b0, gain_q});
    mul_b         = MUL_B_W'(err_c);
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: in_i.ready = 1'b1;
      ST_PREP: div_req.start = (den_c != '0);
      ST_DIV: ;
      ST_MUL_EST: mul_en = 1'b1;
      ST_MUL_VAR: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, GAIN_ONE - gain_q});
        mul_b  = $signed(MUL_B_W'({1'b0, pp_q}));
      end
      ST_UPDATE: out_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      offset_q    <= OFFSET_RESET;
      q_noise_q   <= Q_RESET;
      r_noise_q   <= R_RESET;
      last_est_q  <= '0;
      last_var_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_SAMPLE_OFFSET:     offset_q  <= cfg_i.data[OFFSET_W-1:0];
          REG_PROCESS_NOISE:     q_noise_q <= cfg_i.data[NOISE_W-1:0];
          REG_MEASUREMENT_NOISE: r_noise_q <= cfg_i.data[NOISE_W-1:0];
          default: ;  // drop writes to unknown registers
        endcase
      end
      if (out_load) begin
        last_est_q  <= est_new_q;
        last_var_q  <= var_new_c;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers, captured under the sequencer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      diff_q <= diff_c;
      pp_q   <= pp_sat;
    end
    if (state_q == ST_PREP && den_c == '0) begin
      gain_q <= '0;
    end else if (state_q == ST_DIV && div_rsp.done) begin
      gain_q <= div_rsp.quot;
    end
    if (state_q == ST_MUL_VAR) begin
      est_new_q <= est_sat_c;
    end
    if (out_load) begin
      est_out_q <= est_new_q;
      var_out_q <= var_new_c;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.estimate = est_out_q;
  assign out_o.variance = var_out_q;

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide step");

  a_gain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL_EST) |-> (gain_q <= GAIN_ONE))
    else $error("gain above one");

  a_var_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (var_new_c <= pp_q))
    else $error("updated variance exceeds predicted variance");

  a_update_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && out_valid_q && !out_o.ready) |=> (state_q == ST_UPDATE))
    else $error("update left while the output register was full");

  a_zero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PREP && den_c == '0) |=> (state_q == ST_MUL_EST && gain_q == '0))
    else $error("zero denominator did not force a zero gain");

endmodule
